[hdl/rrts_pkg.sv]
// shared types and codes for the round-robin thread scheduler
// request/response payload structs, table entry layout, opcode and status codes
// no dependencies
package rrts_pkg;

	localparam logic [1:0] OP_SCHED  = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_SET    = 2'd2;
	localparam logic [1:0] OP_SWITCH = 2'd3;

	localparam logic [1:0] ST_UNUSED  = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_ACTIVE  = 2'd2;
	localparam logic [1:0] ST_BLOCKED = 2'd3;

	localparam logic [4:0] READY_SAT = 5'd31;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  thread_index;
		logic [1:0]  entry_status;
		logic        entry_timed_wait;
		logic        entry_idle_role;
		logic [31:0] entry_deadline;
	} rrts_req_t;

	typedef struct packed {
		logic [3:0]  running_now;
		logic        load_context;
		logic        save_context;
		logic [3:0]  previous_thread;
		logic [4:0]  ready_total;
		logic [31:0] time_now;
	} rrts_rsp_t;

	typedef struct packed {
		logic [1:0] status;
		logic       timed;
		logic       idle;
	} rrts_ent_t;

endpackage

[hdl/rrts_table.sv]
// thread table: status/flag memory and deadline memory, one read and one write port
// entries never written read as their reset value through per-entry valid bits
// depends on rrts_pkg
module rrts_table #(
	parameter int THREADS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(THREADS)-1:0] rd_addr,
	output rrts_pkg::rrts_ent_t        rd_ent,
	output logic [31:0]                rd_dl,
	input  logic                       wr_en,
	input  logic [$clog2(THREADS)-1:0] wr_addr,
	input  rrts_pkg::rrts_ent_t        wr_ent,
	input  logic                       wr_dl_en,
	input  logic [31:0]                wr_dl
);
	import rrts_pkg::*;

	localparam int IW = $clog2(THREADS);
	localparam logic [IW-1:0] IDLE_ID = IW'(THREADS - 1);

	rrts_ent_t      ent_mem [THREADS];
	logic [31:0]    dl_mem  [THREADS];
	logic [THREADS-1:0] vld_q;

	rrts_ent_t      ent_s1;
	logic [31:0]    dl_s1;
	logic           vld_s1;
	logic [IW-1:0]  addr_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_mem[wr_addr] <= wr_ent;
		end
		if (wr_dl_en) begin
			dl_mem[wr_addr] <= wr_dl;
		end
		if (rd_en) begin
			ent_s1  <= ent_mem[rd_addr];
			dl_s1   <= dl_mem[rd_addr];
			addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// unwritten entry: unused, except the idle slot which starts ready
	always_comb begin
		if (vld_s1) begin
			rd_ent = ent_s1;
		end else begin
			rd_ent.status = (addr_s1 == IDLE_ID) ? ST_READY : ST_UNUSED;
			rd_ent.timed  = 1'b0;
			rd_ent.idle   = (addr_s1 == IDLE_ID);
		end
	end

	assign rd_dl = dl_s1;

endmodule

[hdl/rrts_ctrl.sv]
// scheduler sequencer: read-modify-write of the thread table, round-robin search,
// tick sweep, ready counter, running thread and system time
// depends on rrts_pkg
module rrts_ctrl #(
	parameter int THREADS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  rrts_pkg::rrts_req_t        req,
	input  logic [15:0]                tick_interval,
	output logic                       res_valid,
	input  logic                       res_free,
	output rrts_pkg::rrts_rsp_t        res,
	output logic                       rd_en,
	output logic [$clog2(THREADS)-1:0] rd_addr,
	input  rrts_pkg::rrts_ent_t        rd_ent,
	input  logic [31:0]                rd_dl,
	output logic                       wr_en,
	output logic [$clog2(THREADS)-1:0] wr_addr,
	output rrts_pkg::rrts_ent_t        wr_ent,
	output logic                       wr_dl_en,
	output logic [31:0]                wr_dl
);
	import rrts_pkg::*;

	localparam int IW = $clog2(THREADS);
	localparam int CW = $clog2(THREADS + 1);
	localparam logic [IW-1:0] IDLE_ID = IW'(THREADS - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SOLD  = 4'd1;
	localparam logic [3:0] S_SRCH  = 4'd2;
	localparam logic [3:0] S_SIDLE = 4'd3;
	localparam logic [3:0] S_TICK  = 4'd4;
	localparam logic [3:0] S_TEND  = 4'd5;
	localparam logic [3:0] S_SET   = 4'd6;
	localparam logic [3:0] S_SWCH  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]    st_q, nxt_st;
	rrts_req_t     req_q;
	logic [IW-1:0] running_q, last_q, cand_q, swp_q, chk_addr_s1;
	logic          run_vld_q, load_q, save_q, tick_chk_s1;
	logic [3:0]    prev_q;
	logic [31:0]   time_q;
	logic [CW-1:0] cnt_q;
	rrts_ent_t     old_ent_q;

	logic          cnt_inc, cnt_dec, in_rng, srch_hit, wake;
	logic [IW-1:0] cand_nxt, last_nxt, req_idx;

	function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] i);
		wrap_next = (i == IDLE_ID) ? '0 : IW'(i + 1'b1);
	endfunction

	assign cand_nxt = wrap_next(cand_q);
	assign last_nxt = wrap_next(last_q);
	assign req_idx  = IW'(req.thread_index);
	assign in_rng   = (32'(req.thread_index) < THREADS);
	assign srch_hit = !rd_ent.idle && (rd_ent.status == ST_READY);
	assign wake     = (rd_ent.status == ST_BLOCKED) && rd_ent.timed && (rd_dl < time_q);

	assign req_ready = (st_q == S_IDLE);
	assign res_valid = (st_q == S_DONE) && res_free;

	always_comb begin
		res.running_now     = run_vld_q ? 4'(running_q) : 4'd0;
		res.load_context    = load_q;
		res.save_context    = save_q;
		res.previous_thread = prev_q;
		res.ready_total     = (32'(cnt_q) > 32'(READY_SAT)) ? READY_SAT : 5'(cnt_q);
		res.time_now        = time_q;
	end

	always_comb begin
		nxt_st   = st_q;
		rd_en    = 1'b0;
		rd_addr  = running_q;
		wr_en    = 1'b0;
		wr_addr  = running_q;
		wr_ent   = rd_ent;
		wr_dl_en = 1'b0;
		wr_dl    = req_q.entry_deadline;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req.op)
						OP_SCHED: begin
							if (run_vld_q) begin
								rd_en  = 1'b1;
								nxt_st = S_SOLD;
							end else begin
								nxt_st = S_DONE;
							end
						end
						OP_TICK: nxt_st = S_TICK;
						OP_SET: begin
							if (in_rng) begin
								rd_en   = 1'b1;
								rd_addr = req_idx;
								nxt_st  = S_SET;
							end else begin
								nxt_st = S_DONE;
							end
						end
						default: begin
							if (in_rng && run_vld_q) begin
								rd_en  = 1'b1;
								nxt_st = S_SWCH;
							end else begin
								nxt_st = S_DONE;
							end
						end
					endcase
				end
			end
			S_SOLD: begin
				// demote the running thread, start the search after the last pick
				rd_en   = 1'b1;
				rd_addr = last_nxt;
				if (rd_ent.status == ST_ACTIVE) begin
					wr_en         = 1'b1;
					wr_ent.status = ST_READY;
					cnt_inc       = 1'b1;
				end
				nxt_st = S_SRCH;
			end
			S_SRCH: begin
				if (cand_q == running_q) begin
					// search came back around to the old thread
					if (old_ent_q.status == ST_READY || running_q == IDLE_ID) begin
						wr_en         = 1'b1;
						wr_ent        = old_ent_q;
						wr_ent.status = ST_ACTIVE;
						cnt_dec       = (old_ent_q.status == ST_READY);
						nxt_st        = S_DONE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = IDLE_ID;
						nxt_st  = S_SIDLE;
					end
				end else if (srch_hit) begin
					wr_en         = 1'b1;
					wr_addr       = cand_q;
					wr_ent.status = ST_ACTIVE;
					cnt_dec       = 1'b1;
					nxt_st        = S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = cand_nxt;
				end
			end
			S_SIDLE: begin
				wr_en         = 1'b1;
				wr_addr       = IDLE_ID;
				wr_ent.status = ST_ACTIVE;
				cnt_dec       = (rd_ent.status == ST_READY);
				nxt_st        = S_DONE;
			end
			S_TICK: begin
				rd_en   = 1'b1;
				rd_addr = swp_q;
				if (swp_q == IDLE_ID) begin
					nxt_st = S_TEND;
				end
			end
			S_TEND: nxt_st = S_DONE;
			S_SET: begin
				wr_en        = 1'b1;
				wr_addr      = IW'(req_q.thread_index);
				wr_ent.status = req_q.entry_status;
				wr_ent.timed = req_q.entry_timed_wait;
				wr_ent.idle  = req_q.entry_idle_role;
				wr_dl_en     = 1'b1;
				cnt_inc      = (req_q.entry_status == ST_READY) && (rd_ent.status != ST_READY);
				cnt_dec      = (req_q.entry_status != ST_READY) && (rd_ent.status == ST_READY);
				nxt_st       = S_DONE;
			end
			S_SWCH: begin
				wr_en         = 1'b1;
				wr_ent.status = ST_READY;
				cnt_inc       = (rd_ent.status != ST_READY);
				nxt_st        = S_DONE;
			end
			S_DONE: begin
				if (res_free) begin
					nxt_st = S_IDLE;
				end
			end
			default: nxt_st = S_IDLE;
		endcase
		// tick sweep: check the entry read in the previous cycle
		if (tick_chk_s1 && wake) begin
			wr_en         = 1'b1;
			wr_addr       = chk_addr_s1;
			wr_ent.status = ST_READY;
			cnt_inc       = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			running_q   <= '0;
			run_vld_q   <= 1'b0;
			last_q      <= '0;
			time_q      <= '0;
			cnt_q       <= CW'(1);
			cand_q      <= '0;
			swp_q       <= '0;
			old_ent_q   <= '0;
			load_q      <= 1'b0;
			save_q      <= 1'b0;
			prev_q      <= '0;
			tick_chk_s1 <= 1'b0;
			chk_addr_s1 <= '0;
		end else begin
			st_q        <= nxt_st;
			tick_chk_s1 <= (st_q == S_TICK);
			chk_addr_s1 <= swp_q;
			if (cnt_inc && !cnt_dec) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cnt_dec && !cnt_inc) begin
				cnt_q <= cnt_q - 1'b1;
			end
			unique case (st_q)
				S_IDLE: begin
					if (req_valid) begin
						// with nothing running, schedule and switch start a thread at once
						load_q <= !run_vld_q &&
							((req.op == OP_SCHED) || (req.op == OP_SWITCH && in_rng));
						save_q <= 1'b0;
						prev_q <= run_vld_q ? 4'(running_q) : 4'd0;
						case (req.op)
							OP_SCHED: begin
								if (!run_vld_q) begin
									running_q <= IDLE_ID;
									last_q    <= IDLE_ID;
									run_vld_q <= 1'b1;
								end
							end
							OP_TICK: begin
								time_q <= time_q + 32'(tick_interval);
								swp_q  <= '0;
							end
							OP_SET: ;
							default: begin
								if (in_rng && !run_vld_q) begin
									running_q <= req_idx;
									run_vld_q <= 1'b1;
								end
							end
						endcase
					end
				end
				S_SOLD: begin
					save_q           <= (rd_ent.status != ST_UNUSED);
					old_ent_q.status <= (rd_ent.status == ST_ACTIVE) ? ST_READY : rd_ent.status;
					old_ent_q.timed  <= rd_ent.timed;
					old_ent_q.idle   <= rd_ent.idle;
					cand_q           <= last_nxt;
				end
				S_SRCH: begin
					if (cand_q != running_q) begin
						if (srch_hit) begin
							running_q <= cand_q;
							last_q    <= cand_q;
							load_q    <= 1'b1;
						end else begin
							cand_q <= cand_nxt;
						end
					end
				end
				S_SIDLE: begin
					running_q <= IDLE_ID;
					last_q    <= IDLE_ID;
					load_q    <= 1'b1;
				end
				S_TICK: swp_q <= IW'(swp_q + 1'b1);
				S_SWCH: begin
					save_q    <= (rd_ent.status != ST_UNUSED);
					last_q    <= running_q;
					running_q <= IW'(req_q.thread_index);
					load_q    <= 1'b1;
				end
				S_TEND, S_SET, S_DONE: ;
				default: ;
			endcase
		end
	end

endmodule

[hdl/round_robin_thread_scheduler.sv]
// Round-robin thread scheduler with an idle thread.
// One request channel (req_valid/req_ready, payload req) carries schedule, tick,
// set-entry and switch operations; every request gives exactly one response on
// rsp_valid/rsp_ready (payload rsp). cfg_we/cfg_wdata write the tick interval,
// reset value 10; write it only while no request is in flight.
// Requests are taken one at a time. What each request does before its response:
//   schedule or switch with nothing running, set or switch out of range: no table access
//   schedule: a read of the running thread, then a search, one table entry read per cycle
//   tick: a sweep that reads every entry once
//   set, and switch with a thread running: one read and one write-back
// The state table sits in a one-port-read, one-port-write memory with a registered
// read; the sequencer reads, modifies and writes back one entry per cycle.
// At reset every entry reads as unused (the idle entry THREADS-1 as ready) via
// per-entry valid bits, so there is no clearing pass; nothing runs and time is 0.
// A response waits in an output register while the receiver stalls; the next
// request is accepted meanwhile and its response holds until the register frees.
// depends on rrts_pkg, rrts_ctrl, rrts_table
module round_robin_thread_scheduler #(
	parameter int THREADS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rrts_pkg::rrts_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rrts_pkg::rrts_rsp_t rsp,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata
);
	import rrts_pkg::*;

	localparam int IW = $clog2(THREADS);

	logic [15:0]   tick_q;
	logic          rsp_valid_q, res_valid, res_free;
	rrts_rsp_t     rsp_q, res;
	logic          rd_en, wr_en, wr_dl_en;
	logic [IW-1:0] rd_addr, wr_addr;
	rrts_ent_t     rd_ent, wr_ent;
	logic [31:0]   rd_dl, wr_dl;

	assign res_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= 16'd10;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tick_q <= cfg_wdata;
			end
			if (res_valid) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	rrts_ctrl #(
		.THREADS(THREADS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.tick_interval(tick_q),
		.res_valid    (res_valid),
		.res_free     (res_free),
		.res          (res),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_ent       (rd_ent),
		.rd_dl        (rd_dl),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_ent       (wr_ent),
		.wr_dl_en     (wr_dl_en),
		.wr_dl        (wr_dl)
	);

	rrts_table #(
		.THREADS(THREADS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_ent  (rd_ent),
		.rd_dl   (rd_dl),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_ent  (wr_ent),
		.wr_dl_en(wr_dl_en),
		.wr_dl   (wr_dl)
	);

endmodule
